@@ design/lbef_pkg.sv @@
// ----------------------------------------------------------------------------
// lbef_pkg: shared types and constants of the LED brightness fader
// Register codes, request codes, sequencer states, and the control structs
// that travel between the core and the ease unit.
// ----------------------------------------------------------------------------
package lbef_pkg;

    localparam int PCT_W     = 7;
    localparam int TIME_W    = 16;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] EASE_TIME_RST  = 16'd1000;
    localparam logic [PCT_W-1:0]  LEVEL_LOW_RST  = 7'd0;
    localparam logic [PCT_W-1:0]  LEVEL_HIGH_RST = 7'd100;

    // Request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // floor(n/100) as (n * DUTY_RECIP) >> DUTY_SHIFT, exact for n <= 25500
    localparam logic [27:0] DUTY_RECIP = 28'd5243;
    localparam int          DUTY_SHIFT = 19;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CALC,
        CS_EMIT
    } t_ctl_state;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_DIV,
        ES_SQ1,
        ES_SQ2,
        ES_MIX1,
        ES_MIX2,
        ES_DONE
    } t_ease_state;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] ease_time;
        logic [PCT_W-1:0]  lvl_from;
        logic [PCT_W-1:0]  lvl_to;
    } t_ease_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] level;
    } t_ease_rsp;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = 15'(pct) * 15'd255;
        prod   = 28'(scaled) * DUTY_RECIP;
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

@@ design/lbef_in_if.sv @@
// ----------------------------------------------------------------------------
// lbef_in_if: request channel of the fader
// Carries one tick or start request per beat.
// ----------------------------------------------------------------------------
interface lbef_in_if;

    logic valid;
    logic ready;
    logic req_type;
    logic fade_up;

    modport source (output valid, output req_type, output fade_up, input ready);
    modport sink   (input valid, input req_type, input fade_up, output ready);

endinterface

@@ design/lbef_out_if.sv @@
// ----------------------------------------------------------------------------
// lbef_out_if: result channel of the fader
// Carries brightness, PWM duty and the fading flag, one beat per request.
// ----------------------------------------------------------------------------
interface lbef_out_if import lbef_pkg::*;;

    logic              valid;
    logic              ready;
    logic [PCT_W-1:0]  brightness_pct;
    logic [DUTY_W-1:0] pwm_duty;
    logic              fading;

    modport source (output valid, output brightness_pct, output pwm_duty,
                    output fading, input ready);
    modport sink   (input valid, input brightness_pct, input pwm_duty,
                    input fading, output ready);

endinterface

@@ design/led_brightness_easing_fader_core.sv @@
// ----------------------------------------------------------------------------
// led_brightness_easing_fader_core: eased LED brightness fader
// Fades a brightness percentage between two levels along an ease-in-out
// quartic curve and reports it with an 8-bit PWM duty.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request per beat: req_type 1 starts a fade (fade_up
//   picks the direction), req_type 0 is the one-millisecond tick. Every
//   request gives exactly one beat on o_out: brightness, duty and fading.
//   Configuration (duration, low and high level) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight; levels
//   take effect at the next start, the duration at the next tick.
// Sequencing:
//   A start, or a tick once the fade has settled, goes from accept
//   straight to the emit state; a tick whose elapsed count has reached
//   the duration skips the divider. Any other tick runs the divider
//   for the fade fraction, FRAC_BITS quotient bits, then four passes
//   through the shared multiplier.
//   One request is in flight at a time; i_in.ready is high only when idle.
// Reset:
//   Synchronous, active low; registers return to their defaults (1000 ms,
//   0 %, 100 %), brightness, target and elapsed count clear to zero.
// Stall:
//   A result waits in the output register while o_out.ready is low; the
//   next request may be accepted meanwhile, its result waits behind it.
// ----------------------------------------------------------------------------
module led_brightness_easing_fader_core import lbef_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data,
    lbef_in_if.sink              i_in,
    lbef_out_if.source           o_out
);

    t_ctl_state r_state, n_state;

    // Configuration registers
    logic [TIME_W-1:0] r_ease_time;
    logic [PCT_W-1:0]  r_level_low;
    logic [PCT_W-1:0]  r_level_high;

    // Fade state
    logic [TIME_W-1:0] r_elapsed;
    logic [PCT_W-1:0]  r_level_now;
    logic [PCT_W-1:0]  r_level_from;
    logic [PCT_W-1:0]  r_level_to;

    // Output register
    logic              r_out_valid;
    logic [PCT_W-1:0]  r_out_pct;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_fading;

    logic              in_ready;
    logic              accept;
    logic              out_free;
    logic              load_out;
    logic              is_start;
    logic              settled;
    logic [TIME_W-1:0] elapsed_inc;
    logic [PCT_W-1:0]  lo_clamped;
    logic [PCT_W-1:0]  hi_clamped;
    t_ease_req         ease_req;
    t_ease_rsp         ease_rsp;

    assign accept      = i_in.valid && in_ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign is_start    = i_in.req_type == REQ_START;
    assign settled     = r_level_now == r_level_to;
    assign elapsed_inc = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + TIME_W'(1);
    assign lo_clamped  = clamp_pct(r_level_low);
    assign hi_clamped  = clamp_pct(r_level_high);

    // Kick the ease unit only for a tick while still fading
    assign ease_req.start     = accept && !is_start && !settled;
    assign ease_req.elapsed   = elapsed_inc;
    assign ease_req.ease_time = r_ease_time;
    assign ease_req.lvl_from  = r_level_from;
    assign ease_req.lvl_to    = r_level_to;

    lbef_ease_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ease_req),
        .o_rsp   (ease_rsp)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    n_state = (!is_start && !settled) ? CS_CALC : CS_EMIT;
                end
            end
            CS_CALC: begin
                if (ease_rsp.done) begin
                    n_state = CS_EMIT;
                end
            end
            CS_EMIT: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ease_time  <= EASE_TIME_RST;
            r_level_low  <= LEVEL_LOW_RST;
            r_level_high <= LEVEL_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EASE_TIME:  r_ease_time  <= i_cfg_data;
                CFG_LEVEL_LOW:  r_level_low  <= i_cfg_data[PCT_W-1:0];
                CFG_LEVEL_HIGH: r_level_high <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Fade state: latch the fade on start, advance the count on tick, take the eased level when the ease unit is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_level_now  <= '0;
            r_level_from <= '0;
            r_level_to   <= '0;
        end else begin
            if (accept) begin
                if (is_start) begin
                    r_elapsed    <= '0;
                    r_level_from <= i_in.fade_up ? lo_clamped : hi_clamped;
                    r_level_to   <= i_in.fade_up ? hi_clamped : lo_clamped;
                end else begin
                    r_elapsed <= elapsed_inc;
                end
            end
            if (r_state == CS_CALC && ease_rsp.done) begin
                r_level_now <= ease_rsp.level;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pct    <= r_level_now;
            r_out_duty   <= pct_to_duty(r_level_now);
            r_out_fading <= !settled;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.brightness_pct = r_out_pct;
    assign o_out.pwm_duty       = r_out_duty;
    assign o_out.fading         = r_out_fading;

    // Checks
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.brightness_pct <= PCT_MAX)
        else $error("brightness above full scale");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ease_rsp.done |-> r_state == CS_CALC)
        else $error("ease unit finished with no tick waiting");

    a_elapsed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && is_start) |=> r_elapsed >= $past(r_elapsed))
        else $error("elapsed count went backward without a start");

endmodule

@@ design/lbef_ease_unit.sv @@
// ----------------------------------------------------------------------------
// lbef_ease_unit: iterative ease-in-out quartic brightness calculator
// Restoring divider for the fade fraction, then one shared multiplier
// for the two squarings and the two blend products.
// ----------------------------------------------------------------------------
module lbef_ease_unit import lbef_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ease_req i_req,
    output t_ease_rsp o_rsp
);

    localparam int MUL_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CNT_W  = $clog2(FRAC_BITS);
    localparam logic [MUL_W-1:0] ONE      = MUL_W'(1) << FRAC_BITS;
    localparam logic [MUL_W-1:0] HALF     = ONE >> 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    t_ease_state r_state, n_state;

    logic [TIME_W-1:0]    r_ease;
    logic [PCT_W-1:0]     r_from;
    logic [PCT_W-1:0]     r_to;
    logic [TIME_W-1:0]    r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [MUL_W-1:0]     r_x;
    logic                 r_lo;
    logic [MUL_W-1:0]     r_sq;
    logic [MUL_W-1:0]     r_fourth;
    logic [PROD_W-1:0]    r_acc;

    logic                 req_sat;
    logic [TIME_W:0]      rem_dbl;
    logic                 div_fit;
    logic [TIME_W-1:0]    rem_next;
    logic [FRAC_BITS-1:0] quo_next;
    logic [MUL_W-1:0]     t_div;
    logic                 lo_div;
    logic [MUL_W-1:0]     x_div;
    logic [MUL_W-1:0]     weight;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [PROD_W-1:0]    prod;
    logic [MUL_W-1:0]     prod_q;
    logic [PROD_W-1:0]    mix;

    // Fraction is one at once for zero duration or a finished fade
    assign req_sat = (i_req.ease_time == '0) || (i_req.elapsed >= i_req.ease_time);

    // One quotient bit a cycle
    assign rem_dbl  = {r_rem, 1'b0};
    assign div_fit  = rem_dbl >= {1'b0, r_ease};
    assign rem_next = div_fit ? TIME_W'(rem_dbl - {1'b0, r_ease}) : TIME_W'(rem_dbl);
    assign quo_next = {r_quo[FRAC_BITS-2:0], div_fit};

    assign t_div  = {1'b0, quo_next};
    assign lo_div = t_div < HALF;
    assign x_div  = lo_div ? t_div : MUL_W'((ONE - t_div) << 1);

    // Ease weight from the fourth power
    assign weight = r_lo ? MUL_W'(r_fourth << 3) : MUL_W'(ONE - (r_fourth >> 1));

    always_comb begin
        case (r_state)
            ES_SQ1: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            ES_SQ2: begin
                mul_a = r_sq;
                mul_b = r_sq;
            end
            ES_MIX1: begin
                mul_a = MUL_W'(r_from);
                mul_b = ONE - weight;
            end
            ES_MIX2: begin
                mul_a = MUL_W'(r_to);
                mul_b = weight;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_q = MUL_W'(prod >> FRAC_BITS);
    assign mix    = r_acc >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_rsp.done  = 1'b0;
        o_rsp.level = (mix > PROD_W'(PCT_MAX)) ? PCT_MAX : mix[PCT_W-1:0];
        unique case (r_state)
            ES_IDLE: begin
                if (i_req.start) begin
                    n_state = req_sat ? ES_SQ1 : ES_DIV;
                end
            end
            ES_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ES_SQ1;
                end
            end
            ES_SQ1:  n_state = ES_SQ2;
            ES_SQ2:  n_state = ES_MIX1;
            ES_MIX1: n_state = ES_MIX2;
            ES_MIX2: n_state = ES_DONE;
            ES_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = ES_IDLE;
            end
            default: n_state = ES_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ES_IDLE: begin
                if (i_req.start) begin
                    r_ease <= i_req.ease_time;
                    r_from <= i_req.lvl_from;
                    r_to   <= i_req.lvl_to;
                    r_rem  <= i_req.elapsed;
                    r_quo  <= '0;
                    r_cnt  <= '0;
                    r_x    <= '0;
                    r_lo   <= 1'b0;
                end
            end
            ES_DIV: begin
                r_rem <= rem_next;
                r_quo <= quo_next;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_x  <= x_div;
                    r_lo <= lo_div;
                end
            end
            ES_SQ1:  r_sq     <= prod_q;
            ES_SQ2:  r_fourth <= prod_q;
            ES_MIX1: r_acc    <= prod;
            ES_MIX2: r_acc    <= r_acc + prod;
            default: ;
        endcase
    end

endmodule
